// File: sv/lsgm_pkg.sv
package lsgm_pkg;

  localparam int SUM_W = 52;
  localparam int PROD_W = 104;
  localparam int NUM_W = 100;
  localparam int REM_W = 105;
  localparam int INV_W = 48;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [62:0] DET_MIN_RESET = 63'd28;
  localparam logic [5:0] MUL_LAST = 6'd51;
  localparam logic [6:0] DIV_FIRST = 7'd99;

  typedef enum logic [1:0] {
    SEL_XX,
    SEL_YY,
    SEL_XY
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_WR,
    ST_ACC_RD2,
    ST_ACC_WR2,
    ST_RD_LOAD,
    ST_MUL,
    ST_DET,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               mode;
    logic [9:0]         left_cell;
    logic [9:0]         right_cell;
    logic               has_right;
    logic signed [23:0] left_x;
    logic signed [23:0] left_y;
    logic signed [23:0] other_x;
    logic signed [23:0] other_y;
  } in_item_t;

  typedef struct packed {
    logic [9:0]               cell_index;
    logic signed [INV_W-1:0]  inv_xx;
    logic signed [INV_W-1:0]  inv_yy;
    logic signed [INV_W-1:0]  inv_xy;
    logic                     singular;
  } out_item_t;

  function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                                      logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

// File: sv/least_squares_gradient_matrix.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | lsgm_pkg::in_item_t
// out_    | output    | out_valid/out_stall | lsgm_pkg::out_item_t
// cfg_    | input     | cfg_valid/cfg_ready | det_min, 63 bits
//
// An accumulate item makes one read and one write of the single sums memory per cell.
// A read item for a cell in range runs the shift-add multiplier and, unless the
// determinant is singular, the three restoring divisions; then it waits for the
// output register.
// After reset a clearing pass zeroes the memory; no item is taken then.
// A stalled result holds in the output register while accumulate items go on.
module least_squares_gradient_matrix #(
  parameter int CELLS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsgm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lsgm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [62:0]         cfg_data
);
  import lsgm_pkg::*;

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int MW = 3 * SUM_W;

  // Memory word: {sum_dx_sq, sum_dy_sq, sum_dx_dy}.
  logic [MW-1:0] mem [CELLS];
  logic [MW-1:0] rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [62:0] det_min_r;
  in_item_t item_r;
  logic signed [SUM_W-1:0] xx_r, yy_r, xy_r;
  logic signed [SUM_W-1:0] sxx_r, syy_r;
  logic [SUM_W-1:0] axy_r, mag_xy_r;
  logic neg_xy_r;
  logic [PROD_W-1:0] p_r, q_r, det_r;
  logic [5:0] mul_cnt_r;
  logic [6:0] div_cnt_r;
  div_sel_t sel_r;
  logic [REM_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic signed [INV_W-1:0] res_xx_r, res_yy_r, res_xy_r;
  logic sing_r;
  logic out_valid_r;
  out_item_t out_r;

  logic accept, out_load, lc_ok, rc_ok;
  logic signed [24:0] dx, dy;
  logic [MW-1:0] acc_word;
  logic [SUM_W-1:0] num_mag;
  logic num_neg;
  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] rem_sh, rem_new;
  logic [NUM_W-1:0] quo_new, lim;
  logic [INV_W-1:0] mag_res;
  logic signed [INV_W-1:0] res_val;
  logic [PROD_W-1:0] det_w;
  logic det_sing;

  assign accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign lc_ok = 32'(item_r.left_cell) < CELLS;
  assign rc_ok = 32'(item_r.right_cell) < CELLS;

  assign dx = 25'(in_data.other_x) - 25'(in_data.left_x);
  assign dy = 25'(in_data.other_y) - 25'(in_data.left_y);

  assign acc_word = {sat_add(rdata_r[3*SUM_W-1:2*SUM_W], xx_r),
                     sat_add(rdata_r[2*SUM_W-1:SUM_W], yy_r),
                     sat_add(rdata_r[SUM_W-1:0], xy_r)};

  // Numerator of the current division, shifted up by 48 bits.
  always_comb begin
    num_mag = SUM_W'(syy_r);
    num_neg = 1'b0;
    case (sel_r)
      SEL_XX: num_mag = SUM_W'(syy_r);
      SEL_YY: num_mag = SUM_W'(sxx_r);
      SEL_XY: begin
        num_mag = mag_xy_r;
        num_neg = neg_xy_r;
      end
      default: num_mag = SUM_W'(syy_r);
    endcase
  end
  assign num = {num_mag, 48'd0};
  assign rem_sh = {rem_r[REM_W-2:0], num[div_cnt_r]};
  always_comb begin
    if (rem_sh >= {1'b0, det_r}) begin
      rem_new = rem_sh - {1'b0, det_r};
      quo_new = {quo_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_new = rem_sh;
      quo_new = {quo_r[NUM_W-2:0], 1'b0};
    end
  end
  assign lim = num_neg ? (NUM_W'(1) << 47) : ((NUM_W'(1) << 47) - NUM_W'(1));
  assign mag_res = (quo_new > lim) ? lim[INV_W-1:0] : quo_new[INV_W-1:0];
  assign res_val = num_neg ? -$signed(mag_res) : $signed(mag_res);

  assign det_w = p_r - q_r;
  assign det_sing = (p_r <= q_r) || (det_w <= PROD_W'(det_min_r));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_cnt_r <= '0;
      det_min_r <= DET_MIN_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        det_min_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall = 1'b1;
    rd_en = 1'b0;
    rd_addr = AW'(in_data.left_cell);
    wr_en = 1'b0;
    wr_addr = AW'(item_r.left_cell);
    wr_data = acc_word;
    out_load = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
        if (32'(clr_cnt_r) == CELLS - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_en = in_valid;
        if (in_valid) begin
          state_nxt = in_data.mode ? ST_RD_LOAD : ST_ACC_WR;
        end
      end
      ST_ACC_WR: begin
        wr_en = lc_ok;
        state_nxt = item_r.has_right ? ST_ACC_RD2 : ST_IDLE;
      end
      ST_ACC_RD2: begin
        rd_en = 1'b1;
        rd_addr = AW'(item_r.right_cell);
        state_nxt = ST_ACC_WR2;
      end
      ST_ACC_WR2: begin
        wr_en = rc_ok;
        wr_addr = AW'(item_r.right_cell);
        state_nxt = ST_IDLE;
      end
      ST_RD_LOAD: begin
        wr_en = lc_ok;
        wr_data = '0;
        state_nxt = lc_ok ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        if (mul_cnt_r == MUL_LAST) begin
          state_nxt = ST_DET;
        end
      end
      ST_DET: begin
        state_nxt = det_sing ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == '0 && sel_r == SEL_XY) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_r <= in_data;
          xx_r <= SUM_W'(dx * dx);
          yy_r <= SUM_W'(dy * dy);
          xy_r <= SUM_W'(dx * dy);
        end
      end
      ST_RD_LOAD: begin
        sxx_r <= rdata_r[3*SUM_W-1:2*SUM_W];
        syy_r <= rdata_r[2*SUM_W-1:SUM_W];
        axy_r <= rdata_r[SUM_W-1] ? SUM_W'(-$signed(rdata_r[SUM_W-1:0]))
                                  : rdata_r[SUM_W-1:0];
        // The negated cross sum saturates when the stored sum is the most negative.
        if (rdata_r[SUM_W-1:0] == SUM_MIN) begin
          mag_xy_r <= SUM_MAX;
          neg_xy_r <= 1'b0;
        end else begin
          mag_xy_r <= rdata_r[SUM_W-1] ? SUM_W'(-$signed(rdata_r[SUM_W-1:0]))
                                       : rdata_r[SUM_W-1:0];
          neg_xy_r <= !rdata_r[SUM_W-1] && (rdata_r[SUM_W-1:0] != '0);
        end
        sing_r <= 1'b1;
        res_xx_r <= '0;
        res_yy_r <= '0;
        res_xy_r <= '0;
        p_r <= '0;
        q_r <= '0;
        mul_cnt_r <= '0;
      end
      ST_MUL: begin
        if (syy_r[mul_cnt_r]) begin
          p_r <= p_r + (PROD_W'(SUM_W'(sxx_r)) << mul_cnt_r);
        end
        if (axy_r[mul_cnt_r]) begin
          q_r <= q_r + (PROD_W'(axy_r) << mul_cnt_r);
        end
        mul_cnt_r <= mul_cnt_r + 6'd1;
      end
      ST_DET: begin
        det_r <= det_w;
        sel_r <= SEL_XX;
        div_cnt_r <= DIV_FIRST;
        rem_r <= '0;
        quo_r <= '0;
      end
      ST_DIV: begin
        if (div_cnt_r == '0) begin
          case (sel_r)
            SEL_XX: res_xx_r <= res_val;
            SEL_YY: res_yy_r <= res_val;
            SEL_XY: begin
              res_xy_r <= res_val;
              sing_r <= 1'b0;
            end
            default: res_xx_r <= res_val;
          endcase
          sel_r <= (sel_r == SEL_XX) ? SEL_YY : SEL_XY;
          div_cnt_r <= DIV_FIRST;
          rem_r <= '0;
          quo_r <= '0;
        end else begin
          div_cnt_r <= div_cnt_r - 7'd1;
          rem_r <= rem_new;
          quo_r <= quo_new;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.cell_index <= item_r.left_cell;
      out_r.inv_xx <= res_xx_r;
      out_r.inv_yy <= res_yy_r;
      out_r.inv_xy <= res_xy_r;
      out_r.singular <= sing_r;
    end
  end

endmodule

// File: sv/lsgm_checker.sv
module lsgm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lsgm_pkg::out_item_t out_data
);
  import lsgm_pkg::*;

  // The clearing pass follows reset, so no result can appear straight after it.
  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.inv_xx == '0 && out_data.inv_yy == '0 && out_data.inv_xy == '0)
    else $error("singular item with nonzero entries");

  a_diag_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.singular |-> !out_data.inv_xx[INV_W-1] && !out_data.inv_yy[INV_W-1])
    else $error("negative diagonal entry");

endmodule

bind least_squares_gradient_matrix lsgm_checker u_lsgm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);

// File: sim/tb_least_squares_gradient_matrix.sv
`timescale 1ns / 1ps

module tb_least_squares_gradient_matrix;
  import lsgm_pkg::*;

  localparam int NCELLS = 1024;
  localparam logic [62:0] DET_MIN_MAX = {63{1'b1}};
  localparam int SETTLE_CYCLES = 400;

  class gradient_scoreboard;
    longint sxx_mem[NCELLS];
    longint syy_mem[NCELLS];
    longint sxy_mem[NCELLS];
    logic [62:0] det_min;
    out_item_t pending_inverses[$];
    int errors;

    function new();
      det_min = DET_MIN_RESET;
      errors = 0;
      foreach (sxx_mem[i]) begin
        sxx_mem[i] = 0;
        syy_mem[i] = 0;
        sxy_mem[i] = 0;
      end
    endfunction

    function longint sat_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (s > longint'(SUM_MAX)) return longint'(SUM_MAX);
      if (s < longint'(SUM_MIN)) return longint'(SUM_MIN);
      return s;
    endfunction

    function void accumulate_cell(int c, longint xx, longint yy, longint xy);
      sxx_mem[c] = sat_sum(sxx_mem[c], xx);
      syy_mem[c] = sat_sum(syy_mem[c], yy);
      sxy_mem[c] = sat_sum(sxy_mem[c], xy);
    endfunction

    // (s * 2^48) / det, truncated toward zero and saturated to 48 bits.
    function logic [INV_W-1:0] scaled_inverse(longint s, logic [127:0] det);
      logic neg;
      logic [127:0] mag;
      logic [127:0] quo;
      logic [127:0] lim;
      neg = s < 0;
      mag = neg ? 128'(-s) : 128'(s);
      lim = neg ? 128'(64'd140737488355328) : 128'(64'd140737488355327);
      quo = (mag << 48) / det;
      if (quo > lim) quo = lim;
      if (neg) quo = -quo;
      return quo[INV_W-1:0];
    endfunction

    function void note_input(in_item_t it);
      longint dx, dy, sxx, syy, sxy;
      logic signed [127:0] p, q;
      logic [127:0] det;
      out_item_t res;
      if (it.mode == 1'b0) begin
        dx = longint'(it.other_x) - longint'(it.left_x);
        dy = longint'(it.other_y) - longint'(it.left_y);
        accumulate_cell(it.left_cell, dx * dx, dy * dy, dx * dy);
        if (it.has_right) accumulate_cell(it.right_cell, dx * dx, dy * dy, dx * dy);
        return;
      end
      res = '0;
      res.cell_index = it.left_cell;
      res.singular = 1'b1;
      sxx = sxx_mem[it.left_cell];
      syy = syy_mem[it.left_cell];
      sxy = sxy_mem[it.left_cell];
      sxx_mem[it.left_cell] = 0;
      syy_mem[it.left_cell] = 0;
      sxy_mem[it.left_cell] = 0;
      p = 128'(sxx);
      p = p * 128'(syy);
      q = 128'(sxy);
      q = q * q;
      // A negative determinant only follows a saturated sum and counts as singular.
      if (p > q) begin
        det = p - q;
        if (det > 128'(det_min)) begin
          res.inv_xx = scaled_inverse(syy, det);
          res.inv_yy = scaled_inverse(sxx, det);
          res.inv_xy = scaled_inverse(sxy == longint'(SUM_MIN) ?
                                      longint'(SUM_MAX) : -sxy, det);
          res.singular = 1'b0;
        end
      end
      pending_inverses.insert(pending_inverses.size(), res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (pending_inverses.size() == 0) begin
        $error("result for cell %0d with nothing expected", got.cell_index);
        errors++;
        return;
      end
      exp_res = pending_inverses.pop_front();
      if (got.cell_index !== exp_res.cell_index) begin
        $error("cell_index: expected %0d, got %0d", exp_res.cell_index, got.cell_index);
        errors++;
      end
      if (got.inv_xx !== exp_res.inv_xx) begin
        $error("inv_xx: expected %0d, got %0d", exp_res.inv_xx, got.inv_xx);
        errors++;
      end
      if (got.inv_yy !== exp_res.inv_yy) begin
        $error("inv_yy: expected %0d, got %0d", exp_res.inv_yy, got.inv_yy);
        errors++;
      end
      if (got.inv_xy !== exp_res.inv_xy) begin
        $error("inv_xy: expected %0d, got %0d", exp_res.inv_xy, got.inv_xy);
        errors++;
      end
      if (got.singular !== exp_res.singular) begin
        $error("singular: expected %0d, got %0d", exp_res.singular, got.singular);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [62:0] cfg_data;

  gradient_scoreboard sb;
  bit quiet;
  int stall_left;
  int sent;

  least_squares_gradient_matrix dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb_least_squares_gradient_matrix failed");
    $finish;
  end

  // Results are sampled with the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_item_t make_item(logic mode, logic [9:0] lc, logic [9:0] rc,
                                         logic hr, logic [23:0] lx, logic [23:0] ly,
                                         logic [23:0] ox, logic [23:0] oy);
    in_item_t it;
    it.mode = mode;
    it.left_cell = lc;
    it.right_cell = rc;
    it.has_right = hr;
    it.left_x = lx;
    it.left_y = ly;
    it.other_x = ox;
    it.other_y = oy;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    sent++;
  endtask

  task automatic read_cell(logic [9:0] c);
    send_item(make_item(1'b1, c, 10'($urandom), 1'($urandom), 24'($urandom),
                        24'($urandom), 24'($urandom), 24'($urandom)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_inverses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_det_min(logic [62:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.det_min = v;
  endtask

  // Mostly a few faces around one cell followed by a read of it, plus raw noise.
  task automatic random_phase(int count);
    int target;
    int faces;
    logic [9:0] c;
    logic [9:0] rc;
    logic [23:0] bx, by;
    int span;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(0, 3) != 0) begin
        c = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
        faces = $urandom_range(1, 5);
        span = $urandom_range(4, 20);
        for (int f = 0; f < faces; f++) begin
          bx = 24'($urandom_range(0, 1 << 22)) - 24'(1 << 21);
          by = 24'($urandom_range(0, 1 << 22)) - 24'(1 << 21);
          rc = 10'($urandom_range(0, 15));
          send_item(make_item(1'b0, c, rc, 1'($urandom), bx, by,
                              bx + 24'($urandom_range(0, 1 << span)) - 24'(1 << (span - 1)),
                              by + 24'($urandom_range(0, 1 << span)) - 24'(1 << (span - 1))));
        end
        read_cell(c);
      end else begin
        send_item(make_item(1'($urandom), 10'($urandom), 10'($urandom), 1'($urandom),
                            24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)));
      end
    end
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty cell reads as singular.
    read_cell(10'd0);
    // Unit faces along each axis, an interior face into the same cell twice.
    send_item(make_item(1'b0, 10'd5, 10'd3, 1'b0, 24'd0, 24'd0, 24'd4096, 24'd0));
    send_item(make_item(1'b0, 10'd5, 10'd5, 1'b1, 24'd0, 24'd0, 24'd0, 24'd4096));
    send_item(make_item(1'b0, 10'd5, 10'd6, 1'b1, 24'd100, 24'd200, 24'd8292, -24'd4096));
    read_cell(10'd5);
    read_cell(10'd6);
    read_cell(10'd5);
    // Widest differences drive every sum near its saturation bound without reaching it.
    for (int i = 0; i < 8; i++) begin
      send_item(make_item(1'b0, 10'd1023, 10'd9, 1'b1, 24'h800000, 24'h7fffff,
                          24'h7fffff, 24'h800000));
    end
    read_cell(10'd1023);
    read_cell(10'd9);
    for (int i = 0; i < 8; i++) begin
      send_item(make_item(1'b0, 10'd1023, 10'd0, 1'b0, 24'h800000, 24'h800000,
                          24'h7fffff, 24'h7fffff));
    end
    read_cell(10'd1023);
    // Tiny cell spread gives a determinant close to the threshold.
    send_item(make_item(1'b0, 10'd2, 10'd0, 1'b0, 24'd0, 24'd0, 24'd1, 24'd0));
    send_item(make_item(1'b0, 10'd2, 10'd0, 1'b0, 24'd0, 24'd0, 24'd0, 24'd1));
    read_cell(10'd2);

    write_det_min(63'd0);
    send_item(make_item(1'b0, 10'd2, 10'd0, 1'b0, 24'd0, 24'd0, 24'd1, 24'd0));
    send_item(make_item(1'b0, 10'd2, 10'd0, 1'b0, 24'd0, 24'd0, 24'd0, 24'd1));
    read_cell(10'd2);
    random_phase(450);
    write_det_min(DET_MIN_MAX);
    random_phase(200);
    write_det_min({15'd0, 48'($urandom_range(1, 1 << 30)) << 20});
    random_phase(450);
    write_det_min(63'($urandom));
    random_phase(300);
    write_det_min(DET_MIN_RESET);
    quiet = 1'b1;
    random_phase(420);

    drain();
    if (sb.errors == 0) begin
      $display("tb_least_squares_gradient_matrix passed");
    end else begin
      $display("tb_least_squares_gradient_matrix failed");
    end
    $finish;
  end

endmodule
